### src/ics_pkg.sv
// Shared constants for the ceiling square root block.
package ics_pkg;

    localparam int ICS_DATA_WIDTH = 64;
    localparam int ICS_VALUE_W    = 63;
    localparam int ICS_ROOT_W     = 32;

endpackage

### src/ics_divider.sv
// Radix-2 restoring divider shared by all iteration steps of the square root block.
module ics_divider
    import ics_pkg::*;
#(
    parameter int DATA_WIDTH = ICS_DATA_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-2:0] divisor,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quotient
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(W);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    logic [W-1:0]  quo_reg;
    logic [W-1:0]  quo_next;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  rem_next;
    logic [W-2:0]  dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W-1:0]  rem_shift;
    logic          ge;

    always_comb
    begin
        rem_shift = {rem_reg[W-2:0], quo_reg[W-1]};
        ge        = (rem_shift >= {1'b0, dvs_reg});
        rem_next  = ge ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
        quo_next  = {quo_reg[W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_FULL;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_ONE;
                if (cnt_reg == CNT_ONE)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### src/integer_ceil_sqrt_newton.sv
// Top level of the ceiling square root block: Newton sequencer around a shared divider.
//
//   Channel | Signals                          | Payload
//   --------+----------------------------------+------------------
//   input   | value_valid, value_ready         | value (63 bits)
//   output  | root_valid, root_ready           | root (32 bits)
//
// Each Newton step and each final correction step costs one division,
// started in a GO state and awaited in the matching WAIT state.
// A value of zero skips the divider, goes straight to the hold state and returns zero.
// The input is not ready while a transaction is being worked on.
// A finished result waits in the output register; a new transaction is
// taken while it waits, and the next result holds until it has been taken.
module integer_ceil_sqrt_newton
    import ics_pkg::*;
#(
    parameter int DATA_WIDTH = ICS_DATA_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   value_valid,
    output logic                   value_ready,
    input  logic [ICS_VALUE_W-1:0] value,
    output logic                   root_valid,
    input  logic                   root_ready,
    output logic [ICS_ROOT_W-1:0]  root
);

    localparam int W = DATA_WIDTH;
    localparam logic [W-2:0] X_ONE  = (W-1)'(1);
    localparam logic [W-1:0] D_ONE  = W'(1);
    localparam logic [W:0]   S_ONE  = (W+1)'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEWTON_GO,
        ST_NEWTON_WAIT,
        ST_FINAL_GO,
        ST_FINAL_WAIT,
        ST_HOLD
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [W-2:0]         n_reg;
    logic [W-2:0]         n_next;
    logic [W-2:0]         x_reg;
    logic [W-2:0]         x_next;
    logic [ICS_ROOT_W-1:0] root_reg;
    logic [ICS_ROOT_W-1:0] root_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic                 div_start;
    logic                 div_done;
    logic [W-1:0]         div_quo;
    logic [W-2:0]         dvs;
    logic [W-1:0]         dividend;
    logic [W-2:0]         x_dec;
    logic [W:0]           nx_sum;
    logic [W-1:0]         nx;

    always_comb
    begin
        x_dec     = x_reg - X_ONE;
        dvs       = (state_reg == ST_FINAL_GO) ? x_dec : x_reg;
        dividend  = {1'b0, n_reg} + {1'b0, dvs} - D_ONE;
        div_start = (state_reg == ST_NEWTON_GO) || (state_reg == ST_FINAL_GO);
        nx_sum    = {2'b00, x_reg} + {1'b0, div_quo} + S_ONE;
        nx        = nx_sum[W:1];
    end

    ics_divider #(
        .DATA_WIDTH (W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        x_next         = x_reg;
        root_next      = root_reg;
        out_valid_next = out_valid_reg && !root_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (value_valid)
                begin
                    n_next = value[W-2:0];
                    x_next = value[W-2:0];
                    if (value[W-2:0] == '0)
                    begin
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        state_next = ST_NEWTON_GO;
                    end
                end
            end
            ST_NEWTON_GO:
            begin
                state_next = ST_NEWTON_WAIT;
            end
            ST_NEWTON_WAIT:
            begin
                if (div_done)
                begin
                    if (nx < {1'b0, x_reg})
                    begin
                        x_next     = nx[W-2:0];
                        state_next = ST_NEWTON_GO;
                    end
                    else if (x_reg > X_ONE)
                    begin
                        state_next = ST_FINAL_GO;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_FINAL_GO:
            begin
                state_next = ST_FINAL_WAIT;
            end
            ST_FINAL_WAIT:
            begin
                // The square of x - 1 still reaches n exactly when ceil(n / (x - 1)) <= x - 1.
                if (div_done)
                begin
                    if (div_quo <= {1'b0, x_dec})
                    begin
                        x_next = x_dec;
                        if (x_dec > X_ONE)
                        begin
                            state_next = ST_FINAL_GO;
                        end
                        else
                        begin
                            state_next = ST_HOLD;
                        end
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || root_ready)
                begin
                    root_next      = ICS_ROOT_W'(x_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            x_reg         <= '0;
            root_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            x_reg         <= x_next;
            root_reg      <= root_next;
        end
    end

    assign value_ready = (state_reg == ST_IDLE);
    assign root_valid  = out_valid_reg;
    assign root        = root_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_NEWTON_WAIT) || (state_reg == ST_FINAL_WAIT))
        else $error("divider finished outside a wait state");

    a_final_above_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL_GO) |-> (x_reg > X_ONE))
        else $error("final correction started with estimate at or below one");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (value_valid && value_ready) |=> !value_ready)
        else $error("input still ready after a transaction was accepted");

endmodule
